@@ rtl/wfb_pkg.sv @@
package wfb_pkg;

  localparam int unsigned BYTES_PER_WORD = 4;
  localparam int unsigned CMDQ_DEPTH     = 4;
  localparam int unsigned CMDQ_AW        = $clog2(CMDQ_DEPTH);

  localparam logic OP_START = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  localparam logic [1:0] CFG_HEADER   = 2'd0;
  localparam logic [1:0] CFG_TARGET   = 2'd1;
  localparam logic [1:0] CFG_FUNCTION = 2'd2;

  localparam logic [7:0] HEADER_RESET   = 8'hAA;
  localparam logic [7:0] TARGET_RESET   = 8'hFF;
  localparam logic [7:0] FUNCTION_RESET = 8'hF1;

  // byte slots of one command in the back part
  localparam logic [2:0] SLOT_LAST_DATA = 3'd3;
  localparam logic [2:0] SLOT_SUM       = 3'd4;
  localparam logic [2:0] SLOT_ADD       = 3'd5;

  typedef struct packed {
    logic        op;
    logic [5:0]  word_count;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic        fresh;
    logic        close;
    logic [31:0] bytes;
  } cmd_t;

endpackage

@@ rtl/wfb_front.sv @@
module wfb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wfb_pkg::in_item_t item,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output wfb_pkg::cmd_t    q_cmd
);

  logic [7:0] header_byte;
  logic [7:0] target_address;
  logic [7:0] function_code;
  logic [5:0] words_left;
  logic [5:0] words_left_next;
  logic       frame_open;
  logic       frame_open_next;
  logic       accept;

  assign accept = push && !q_full;

  always_comb begin
    q_push          = 1'b0;
    q_cmd.fresh     = 1'b0;
    q_cmd.close     = 1'b0;
    q_cmd.bytes     = item.data_word;
    words_left_next = words_left;
    frame_open_next = frame_open;
    if (item.op == wfb_pkg::OP_START) begin
      q_push          = accept;
      q_cmd.fresh     = 1'b1;
      q_cmd.close     = (item.word_count == 6'd0);
      q_cmd.bytes     = {item.word_count, 2'b00, function_code, target_address, header_byte};
      words_left_next = item.word_count;
      frame_open_next = (item.word_count != 6'd0);
    end else if (frame_open && words_left != 6'd0) begin
      q_push          = accept;
      q_cmd.close     = (words_left == 6'd1);
      words_left_next = words_left - 6'd1;
      frame_open_next = (words_left != 6'd1);
    end
    // words with no frame open are dropped here
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left     <= '0;
      frame_open     <= 1'b0;
      header_byte    <= wfb_pkg::HEADER_RESET;
      target_address <= wfb_pkg::TARGET_RESET;
      function_code  <= wfb_pkg::FUNCTION_RESET;
    end else begin
      if (accept) begin
        words_left <= words_left_next;
        frame_open <= frame_open_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          wfb_pkg::CFG_HEADER:   header_byte    <= cfg_data;
          wfb_pkg::CFG_TARGET:   target_address <= cfg_data;
          wfb_pkg::CFG_FUNCTION: function_code  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/wfb_cmdq.sv @@
module wfb_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  wfb_pkg::cmd_t wdata,
  input  logic          rd,
  output wfb_pkg::cmd_t rdata,
  output logic          full,
  output logic          nonempty
);

  wfb_pkg::cmd_t                  mem [wfb_pkg::CMDQ_DEPTH];
  logic [wfb_pkg::CMDQ_AW-1:0]    wptr;
  logic [wfb_pkg::CMDQ_AW-1:0]    rptr;
  logic [wfb_pkg::CMDQ_AW-1:0]    rptr_next;
  logic [wfb_pkg::CMDQ_AW:0]      count;
  logic                           do_wr;
  logic                           do_rd;

  assign full      = (count == (wfb_pkg::CMDQ_AW + 1)'(wfb_pkg::CMDQ_DEPTH));
  assign nonempty  = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && nonempty;
  assign rptr_next = do_rd ? rptr + 1'b1 : rptr;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
    // head register, fed straight from the write side when the queue runs dry
    if (do_wr && wptr == rptr_next) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[rptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      rptr <= rptr_next;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/wfb_back.sv @@
module wfb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  wfb_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output wfb_pkg::out_item_t result
);

  wfb_pkg::cmd_t cur;
  logic          active;
  logic [2:0]    slot;
  logic [7:0]    sum_acc;
  logic [7:0]    add_acc;
  logic [7:0]    sum_next;
  logic          out_valid;
  logic          emit;
  logic          finish;
  logic [2:0]    last_slot;
  logic [7:0]    data_byte;
  wfb_pkg::out_item_t next_out;

  assign empty     = !out_valid;
  assign emit      = active && (!out_valid || pop);
  assign last_slot = cur.close ? wfb_pkg::SLOT_ADD : wfb_pkg::SLOT_LAST_DATA;
  assign finish    = emit && (slot == last_slot);
  assign q_pop     = q_nonempty && (!active || finish);
  assign data_byte = cur.bytes[slot[1:0]*8 +: 8];
  assign sum_next  = sum_acc + data_byte;

  always_comb begin
    next_out.frame_end = 1'b0;
    case (slot)
      wfb_pkg::SLOT_SUM: next_out.out_byte = sum_acc;
      wfb_pkg::SLOT_ADD: begin
        next_out.out_byte  = add_acc;
        next_out.frame_end = 1'b1;
      end
      default:           next_out.out_byte = data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= next_out;
    end
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      slot      <= '0;
      sum_acc   <= '0;
      add_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // checksum slots leave the sums untouched
      if (q_pop && q_cmd.fresh) begin
        sum_acc <= '0;
        add_acc <= '0;
      end else if (emit && slot <= wfb_pkg::SLOT_LAST_DATA) begin
        sum_acc <= sum_next;
        add_acc <= add_acc + sum_next;
      end
      if (q_pop) begin
        active <= 1'b1;
        slot   <= '0;
      end else if (emit) begin
        if (finish) begin
          active <= 1'b0;
        end
        slot <= slot + 3'd1;
      end
    end
  end

endmodule

@@ rtl/word_frame_builder_sum_add_check.sv @@
// sum-add checksum frame builder, one frame byte per result transaction
// input queue side: push an item while full is low; op start carries the
// word count, op word carries a 32-bit data word; words outside an open
// frame or beyond the count are dropped with no result
// result queue side: while empty is low the oldest byte sits on result;
// pop takes it; frame_end marks the second checksum byte
// config side: cfg_valid writes cfg_data to header (0), target (1) or
// function code (2); cfg_ready is always high; write only while idle
// a front stage tracks the frame and turns each item into a byte command
// in a four-entry command queue; a back stage emits one byte per cycle while
// the receiver keeps popping; the first byte of an item passes the queue head
// register, the back stage command register and its output register; an item
// gives four bytes, six when it closes the frame
// a stalled receiver holds the output register; the command queue then
// fills and full rises after four more items that are not dropped
// reset restores register defaults and empties every queue
module word_frame_builder_sum_add_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wfb_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output wfb_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  wfb_pkg::cmd_t front_cmd;
  wfb_pkg::cmd_t back_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_nonempty;

  assign cfg_ready = 1'b1;

  wfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (q_push),
    .q_cmd     (front_cmd)
  );

  wfb_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wdata    (front_cmd),
    .rd       (q_pop),
    .rdata    (back_cmd),
    .full     (full),
    .nonempty (q_nonempty)
  );

  wfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_cmd      (back_cmd),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PRINT_CAP = 50;

  // frame byte predictor and store of expected bytes
  class frame_scoreboard;
    logic [7:0] hdr_reg;
    logic [7:0] addr_reg;
    logic [7:0] fcode_reg;
    logic [7:0] sum_run;
    logic [7:0] fold_run;
    logic [5:0] words_due;
    bit         in_frame;
    wfb_pkg::out_item_t expected_bytes[$];
    int unsigned bytes_checked;
    int unsigned frames_closed;
    int unsigned words_dropped;

    function new();
      hdr_reg   = wfb_pkg::HEADER_RESET;
      addr_reg  = wfb_pkg::TARGET_RESET;
      fcode_reg = wfb_pkg::FUNCTION_RESET;
      sum_run   = '0;
      fold_run  = '0;
      words_due = '0;
      in_frame  = 1'b0;
      bytes_checked = 0;
      frames_closed = 0;
      words_dropped = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
        wfb_pkg::CFG_HEADER:   hdr_reg = val;
        wfb_pkg::CFG_TARGET:   addr_reg = val;
        wfb_pkg::CFG_FUNCTION: fcode_reg = val;
        default: ;
      endcase
    endfunction

    function void summed_byte(input logic [7:0] b);
      wfb_pkg::out_item_t e;
      sum_run  = sum_run + b;
      fold_run = fold_run + sum_run;
      e.out_byte  = b;
      e.frame_end = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void close_frame();
      wfb_pkg::out_item_t e;
      e.out_byte  = sum_run;
      e.frame_end = 1'b0;
      expected_bytes.push_back(e);
      e.out_byte  = fold_run;
      e.frame_end = 1'b1;
      expected_bytes.push_back(e);
      in_frame  = 1'b0;
      words_due = '0;
      frames_closed++;
    endfunction

    function void add_item(input wfb_pkg::in_item_t it);
      if (it.op == wfb_pkg::OP_START) begin
        sum_run   = '0;
        fold_run  = '0;
        words_due = it.word_count;
        in_frame  = 1'b1;
        summed_byte(hdr_reg);
        summed_byte(addr_reg);
        summed_byte(fcode_reg);
        summed_byte({it.word_count, 2'b00});
        if (words_due == 0) close_frame();
      end else if (!in_frame || words_due == 0) begin
        words_dropped++;
      end else begin
        for (int i = 0; i < wfb_pkg::BYTES_PER_WORD; i++)
          summed_byte(it.data_word[8*i +: 8]);
        words_due = words_due - 1'b1;
        if (words_due == 0) close_frame();
      end
    endfunction

    function string check_byte(input wfb_pkg::out_item_t got);
      wfb_pkg::out_item_t want;
      string msg;
      msg = "";
      if (expected_bytes.size() == 0) begin
        return $sformatf("unexpected byte %02h frame_end %0b", got.out_byte, got.frame_end);
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte)
        msg = $sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte);
      if (got.frame_end !== want.frame_end)
        msg = {msg, $sformatf(" frame_end %0b, expected %0b", got.frame_end, want.frame_end)};
      return msg;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  wfb_pkg::in_item_t  item = '0;
  logic               empty;
  logic               pop = 1'b0;
  wfb_pkg::out_item_t result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  frame_scoreboard sb = new();
  int unsigned send_idle = 12;
  int unsigned recv_idle = 49;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;

  word_frame_builder_sum_add_check DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiving side: check each popped transaction, then decide the next pop
  always @(posedge clk) begin : result_side
    string msg;
    if (!rst && pop && !empty) begin
      msg = sb.check_byte(result);
      if (msg != "") report_mismatch(msg);
    end
    pop <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic wfb_pkg::in_item_t make_item(input logic op, input logic [5:0] cnt,
                                                  input logic [31:0] w);
    wfb_pkg::in_item_t it;
    it.op = op;
    it.word_count = cnt;
    it.data_word = w;
    return it;
  endfunction

  task automatic send_item(input wfb_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.add_item(it);
    items_sent++;
  endtask

  task automatic start_frame(input logic [5:0] cnt);
    send_item(make_item(wfb_pkg::OP_START, cnt, $urandom));
  endtask

  task automatic send_word(input logic [31:0] w);
    send_item(make_item(wfb_pkg::OP_WORD, 6'($urandom_range(0, 63)), w));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // dropped words may still be in flight without any byte to show for them
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // mostly complete frames; some abandoned early, some followed by a stray word
  task automatic random_frames(input int unsigned target);
    int unsigned useful;
    int unsigned r;
    int unsigned cnt;
    int unsigned nwords;
    bit cut_short;
    useful = 0;
    while (useful < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) cnt = $urandom_range(0, 4);
      else if (r < 90) cnt = $urandom_range(5, 16);
      else if (r < 97) cnt = $urandom_range(17, 62);
      else cnt = 63;
      cut_short = ($urandom_range(0, 9) == 0) && cnt != 0;
      nwords = cut_short ? $urandom_range(0, cnt - 1) : cnt;
      start_frame(6'(cnt));
      useful++;
      for (int i = 0; i < nwords; i++) begin
        send_word(random_word());
        useful++;
      end
      if (!cut_short && $urandom_range(0, 7) == 0) send_word(random_word());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset register values
    start_frame(6'd0);
    send_word(32'hFFFF_FFFF);
    start_frame(6'd1);
    send_word(32'h0000_0000);
    send_word(32'h1234_5678);
    start_frame(6'd2);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0001);
    // a start in the middle of a frame abandons it without checksum bytes
    start_frame(6'd63);
    send_word(32'hA5A5_A5A5);
    send_word(32'h5A5A_5A5A);
    start_frame(6'd3);
    repeat (3) send_word($urandom);
    start_frame(6'd0);

    write_reg(wfb_pkg::CFG_HEADER, 8'h00);
    write_reg(wfb_pkg::CFG_TARGET, 8'h00);
    write_reg(wfb_pkg::CFG_FUNCTION, 8'hFA);
    write_reg(CFG_UNUSED, 8'h55);
    start_frame(6'd1);
    send_word(32'hDEAD_BEEF);
    write_reg(wfb_pkg::CFG_HEADER, 8'hFF);
    write_reg(wfb_pkg::CFG_TARGET, 8'hFF);
    write_reg(wfb_pkg::CFG_FUNCTION, 8'hF1);
    start_frame(6'd0);
    // function code outside its usual range goes out unchanged
    write_reg(wfb_pkg::CFG_FUNCTION, 8'h00);
    start_frame(6'd2);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);

    write_reg(wfb_pkg::CFG_HEADER, 8'($urandom_range(0, 255)));
    write_reg(wfb_pkg::CFG_TARGET, 8'($urandom_range(0, 255)));
    write_reg(wfb_pkg::CFG_FUNCTION, 8'($urandom_range(241, 250)));
    random_frames(75);

    send_idle = 49;
    recv_idle = 12;
    write_reg(wfb_pkg::CFG_HEADER, 8'h00);
    write_reg(wfb_pkg::CFG_TARGET, 8'hFF);
    write_reg(wfb_pkg::CFG_FUNCTION, 8'hFA);
    random_frames(75);

    send_idle = 0;
    recv_idle = 0;
    write_reg(wfb_pkg::CFG_HEADER, 8'($urandom_range(0, 255)));
    write_reg(wfb_pkg::CFG_TARGET, 8'($urandom_range(0, 255)));
    write_reg(wfb_pkg::CFG_FUNCTION, 8'($urandom_range(241, 250)));
    random_frames(75);

    drain();
    repeat (20) @(posedge clk);

    $display("sent %0d items (%0d words dropped outside a frame), %0d register writes",
             items_sent, sb.words_dropped, cfg_writes);
    $display("checked %0d frame bytes over %0d closed frames, %0d mismatches",
             sb.bytes_checked, sb.frames_closed, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
